>>> rtl/core/pdfir_pkg.sv
// ----------------------------------------------------------------------------
// pdfir_pkg
// shared constants, command codes and fixed-point formats for the
// polyphase decimating fir
// ----------------------------------------------------------------------------
package pdfir_pkg;

    localparam int MAX_DECIM_DEF   = 16;
    localparam int TAPS_DEF        = 32;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int INDEX_BITS = 9;
    localparam int COEF_BITS  = 18;
    localparam int FRAC_BITS  = 17;
    localparam int ACC_BITS   = 48;
    localparam int CFG_BITS   = 5;

    localparam logic [CFG_BITS-1:0] DECIM_RESET = 5'd4;

    localparam logic CMD_COEF   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

endpackage

>>> rtl/core/pdfir_rndsat.sv
// ----------------------------------------------------------------------------
// pdfir_rndsat
// round half up from the accumulator's fraction bits and clip to the
// signed output sample range
// ----------------------------------------------------------------------------
module pdfir_rndsat #(
    parameter int SAMPLE_BITS = pdfir_pkg::SAMPLE_BITS_DEF
) (
    input  logic signed [pdfir_pkg::ACC_BITS-1:0] acc,
    output logic        [SAMPLE_BITS-1:0]         filtered,
    output logic                                  saturated
);

    localparam int RND_W = pdfir_pkg::ACC_BITS + 1;
    localparam int QW    = RND_W - pdfir_pkg::FRAC_BITS;
    localparam int LW    = (QW > SAMPLE_BITS) ? QW : SAMPLE_BITS;

    localparam logic signed [LW-1:0] HI = {{(LW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [LW-1:0] LO = {{(LW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [RND_W-1:0] rnd;
    logic signed [RND_W-1:0] shifted;
    logic signed [QW-1:0]    q;
    logic signed [LW-1:0]    q_ext;

    assign rnd     = RND_W'(acc) + RND_W'(1 << (pdfir_pkg::FRAC_BITS - 1));
    assign shifted = rnd >>> pdfir_pkg::FRAC_BITS;
    assign q       = QW'(shifted);
    assign q_ext   = LW'(q);

    always_comb
    begin
        if (q_ext > HI)
        begin
            filtered  = SAMPLE_BITS'(HI);
            saturated = 1'b1;
        end
        else if (q_ext < LO)
        begin
            filtered  = SAMPLE_BITS'(LO);
            saturated = 1'b1;
        end
        else
        begin
            filtered  = SAMPLE_BITS'(q_ext);
            saturated = 1'b0;
        end
    end

endmodule

>>> rtl/core/polyphase_decimating_fir.sv
// ----------------------------------------------------------------------------
// polyphase_decimating_fir
// polyphase decimating fir: delay lines and coefficients in two synchronous
// memories, one multiply-accumulate per tap through a shared multiplier
// ----------------------------------------------------------------------------
// a coefficient request with an in-range index is written to the coefficient memory;
// a sample request passes phase reduction, a tap-serial read-modify-write pass over
// the branch's delay line memory port, accumulation and, when it completes an output,
// the emit state, where a stalled previous output holds the new output request
// back; no new request is taken until the sample request is done
// reset: phase and accumulator clear at once, then a clearing pass over all
// MAX_DECIM * TAPS_PER_PHASE delay line entries (512) zeroes them, no request
// is taken meanwhile; configuration writes are always taken
// ----------------------------------------------------------------------------
module polyphase_decimating_fir #(
    parameter int MAX_DECIM      = pdfir_pkg::MAX_DECIM_DEF,
    parameter int TAPS_PER_PHASE = pdfir_pkg::TAPS_DEF,
    parameter int SAMPLE_BITS    = pdfir_pkg::SAMPLE_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pdfir_pkg::CFG_BITS-1:0]    cfg_data,   // decim_factor

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // coeff_index, coeff_value, sample, zero pad
    input  logic [((pdfir_pkg::INDEX_BITS + pdfir_pkg::COEF_BITS + SAMPLE_BITS + 7) / 8) * 8 - 1:0]
                                              s_axis_tdata,
    input  logic                              s_axis_tuser, // cmd

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // filtered, zero pad
    output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    output logic                              m_axis_tuser  // saturated
);

    localparam int IDX_W     = pdfir_pkg::INDEX_BITS;
    localparam int CF_W      = pdfir_pkg::COEF_BITS;
    localparam int ACC_W     = pdfir_pkg::ACC_BITS;
    localparam int IN_BITS   = IDX_W + CF_W + SAMPLE_BITS;
    localparam int OUT_TD_W  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int DEPTH     = MAX_DECIM * TAPS_PER_PHASE;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PH_W      = (MAX_DECIM > 1) ? $clog2(MAX_DECIM) : 1;
    localparam int M_W       = $clog2(MAX_DECIM + 1);
    localparam int CMP_W     = (M_W > pdfir_pkg::CFG_BITS) ? M_W : pdfir_pkg::CFG_BITS;
    localparam int TC_W      = $clog2(TAPS_PER_PHASE + 1);
    localparam int PROD_W    = CF_W + SAMPLE_BITS;
    localparam int SUM_W     = PROD_W + $clog2(TAPS_PER_PHASE + 1);
    localparam int EXT_W     = ((SUM_W > ACC_W) ? SUM_W : ACC_W) + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_REDUCE,
        S_MAC,
        S_ACCUM,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [pdfir_pkg::CFG_BITS-1:0] decim_reg;
    logic [CMP_W-1:0]               decim_ext;
    logic [M_W-1:0]                 m_eff;

    logic [PH_W-1:0]          phase_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [ADDR_W-1:0]        clr_cnt_reg;
    logic [TC_W-1:0]          issue_cnt_reg;
    logic                     pipe1_valid_reg;
    logic                     pipe2_valid_reg;
    logic [ADDR_W-1:0]        pipe1_addr_reg;
    logic [ADDR_W-1:0]        base_reg;
    logic signed [SAMPLE_BITS-1:0] carry_reg;
    logic signed [PROD_W-1:0] product_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic                     out_valid_reg;
    logic [SAMPLE_BITS-1:0]   filtered_reg;
    logic                     sat_reg;

    logic [IDX_W-1:0]              in_index;
    logic signed [CF_W-1:0]        in_coeff;
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic                          in_accept;

    logic                     issue;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     dl_we;
    logic [ADDR_W-1:0]        dl_waddr;
    logic signed [SAMPLE_BITS-1:0] dl_wdata;
    logic signed [SAMPLE_BITS-1:0] dl_q_reg;
    logic                     cf_we;
    logic signed [CF_W-1:0]   cf_q_reg;

    logic signed [SAMPLE_BITS-1:0] dl_mem [DEPTH];
    logic signed [CF_W-1:0]        cf_mem [DEPTH];

    logic signed [EXT_W-1:0]  acc_sum;
    logic signed [ACC_W-1:0]  acc_clamped;
    logic                     phase_ge;
    logic                     last_branch;
    logic                     mac_done;
    logic                     out_free;
    logic [SAMPLE_BITS-1:0]   rs_filtered;
    logic                     rs_sat;

    assign in_index  = s_axis_tdata[IDX_W-1:0];
    assign in_coeff  = s_axis_tdata[IDX_W+CF_W-1:IDX_W];
    assign in_sample = s_axis_tdata[IN_BITS-1:IDX_W+CF_W];

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TD_W'(filtered_reg);
    assign m_axis_tuser  = sat_reg;

    // branches in use
    assign decim_ext = CMP_W'(decim_reg);
    always_comb
    begin
        if (decim_ext == '0)
            m_eff = M_W'(1);
        else if (decim_ext > CMP_W'(MAX_DECIM))
            m_eff = M_W'(MAX_DECIM);
        else
            m_eff = M_W'(decim_ext);
    end

    assign phase_ge    = (M_W'(phase_reg) >= m_eff);
    assign last_branch = ((M_W'(phase_reg) + M_W'(1)) >= m_eff);
    assign out_free    = !out_valid_reg || m_axis_tready;

    assign issue    = (state_reg == S_MAC) && (issue_cnt_reg != TC_W'(TAPS_PER_PHASE));
    assign rd_addr  = base_reg + ADDR_W'(issue_cnt_reg);
    assign mac_done = (state_reg == S_MAC) && !issue && !pipe1_valid_reg && !pipe2_valid_reg;

    assign dl_we    = (state_reg == S_CLEAR) || pipe1_valid_reg;
    assign dl_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : pipe1_addr_reg;
    assign dl_wdata = (state_reg == S_CLEAR) ? '0 : carry_reg;

    assign cf_we = in_accept && (s_axis_tuser == pdfir_pkg::CMD_COEF)
                   && (32'(in_index) < DEPTH);

    // accumulate with clamp to the accumulator range
    assign acc_sum = EXT_W'(acc_reg) + EXT_W'(sum_reg);
    always_comb
    begin
        if (acc_sum > EXT_W'(pdfir_pkg::ACC_MAX))
            acc_clamped = pdfir_pkg::ACC_MAX;
        else if (acc_sum < EXT_W'(pdfir_pkg::ACC_MIN))
            acc_clamped = pdfir_pkg::ACC_MIN;
        else
            acc_clamped = ACC_W'(acc_sum);
    end

    pdfir_rndsat #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_rndsat (
        .acc       (acc_reg),
        .filtered  (rs_filtered),
        .saturated (rs_sat)
    );

    // memories
    always_ff @(posedge clk)
    begin
        if (dl_we)
            dl_mem[dl_waddr] <= dl_wdata;
        dl_q_reg <= dl_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cf_we)
            cf_mem[ADDR_W'(in_index)] <= in_coeff;
        cf_q_reg <= cf_mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_accept && (s_axis_tuser == pdfir_pkg::CMD_SAMPLE))
                    state_next = S_REDUCE;
            end
            S_REDUCE:
            begin
                if (!phase_ge)
                    state_next = S_MAC;
            end
            S_MAC:
            begin
                if (mac_done)
                    state_next = S_ACCUM;
            end
            S_ACCUM:
            begin
                state_next = last_branch ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            decim_reg       <= pdfir_pkg::DECIM_RESET;
            phase_reg       <= '0;
            acc_reg         <= '0;
            clr_cnt_reg     <= '0;
            issue_cnt_reg   <= '0;
            pipe1_valid_reg <= 1'b0;
            pipe2_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
                decim_reg <= cfg_data;

            if (state_reg == S_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);

            if (state_reg == S_REDUCE && phase_ge)
                phase_reg <= PH_W'(M_W'(phase_reg) - m_eff);

            if (in_accept)
                issue_cnt_reg <= '0;
            else if (issue)
                issue_cnt_reg <= issue_cnt_reg + TC_W'(1);

            pipe1_valid_reg <= issue;
            pipe2_valid_reg <= pipe1_valid_reg;

            if (state_reg == S_ACCUM)
            begin
                acc_reg <= acc_clamped;
                if (!last_branch)
                    phase_reg <= phase_reg + PH_W'(1);
            end

            if (state_reg == S_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
                acc_reg       <= '0;
                phase_reg     <= '0;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            carry_reg <= in_sample;
            sum_reg   <= '0;
        end
        else
        begin
            if (pipe1_valid_reg)
            begin
                product_reg <= PROD_W'(cf_q_reg) * PROD_W'(carry_reg);
                carry_reg   <= dl_q_reg;
            end
            if (pipe2_valid_reg)
                sum_reg <= sum_reg + SUM_W'(product_reg);
        end

        if (state_reg == S_REDUCE)
            base_reg <= ADDR_W'(32'(phase_reg) * TAPS_PER_PHASE);

        pipe1_addr_reg <= rd_addr;

        if (state_reg == S_EMIT && out_free)
        begin
            filtered_reg <= rs_filtered;
            sat_reg      <= rs_sat;
        end
    end

    // tap pipeline only runs inside the mac pass
    a_pipe_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
        (pipe1_valid_reg || pipe2_valid_reg) |-> (state_reg == S_MAC))
        else $error("tap pipeline active outside mac pass");

    // a reduced phase always selects a branch in use
    a_phase_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAC) |-> (M_W'(phase_reg) < m_eff))
        else $error("mac pass on a branch beyond the factor in use");

    // exactly taps reads issued before the pass completes
    a_issue_count: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> (issue_cnt_reg == TC_W'(TAPS_PER_PHASE)))
        else $error("mac pass ended with a wrong tap count");

    // an emitted result shows up on the output next cycle
    a_emit_visible: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free) |=> (m_axis_tvalid && state_reg == S_IDLE))
        else $error("emitted result not presented");

    // no coefficient write lands during the clearing pass
    a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !cf_we)
        else $error("coefficient write during clearing pass");

endmodule

>>> verif/polyphase_decimating_fir_test.sv
// ----------------------------------------------------------------------------
// polyphase_decimating_fir_test
// self-checking bench for the polyphase decimating fir: loads the whole
// coefficient store, runs a directed set of extreme samples and factors, then
// random segments of samples and coefficient rewrites under changing
// decimation factors, with random gaps on the input and stalls on the output;
// every accepted output request is checked against an in-bench filter model
// ----------------------------------------------------------------------------
module polyphase_decimating_fir_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH    = pdfir_pkg::MAX_DECIM_DEF * pdfir_pkg::TAPS_DEF;
    localparam int TAPS     = pdfir_pkg::TAPS_DEF;
    localparam int IDX_BITS = pdfir_pkg::INDEX_BITS;
    localparam int CF_BITS  = pdfir_pkg::COEF_BITS;
    localparam int CFG_W    = pdfir_pkg::CFG_BITS;
    localparam int SMP_BITS = pdfir_pkg::SAMPLE_BITS_DEF;
    localparam int IN_W     = ((IDX_BITS + CF_BITS + SMP_BITS + 7) / 8) * 8;
    localparam int IN_PAD   = IN_W - IDX_BITS - CF_BITS - SMP_BITS;
    localparam int OUT_W    = ((SMP_BITS + 7) / 8) * 8;
    localparam int RAND_REQS  = 1250;
    localparam int SETTLE     = 100;
    localparam int CYCLE_CAP  = 1000000;

    typedef struct {
        logic                      cmd;
        logic [IDX_BITS-1:0]       idx;
        logic signed [CF_BITS-1:0] coeff;
        logic signed [SMP_BITS-1:0] smp;
    } fir_req_t;

    typedef struct {
        logic signed [SMP_BITS-1:0] filtered;
        logic                       saturated;
    } fir_out_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data  = '0;

    logic            s_axis_tvalid = 1'b0;
    logic            s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata  = '0; // coeff_index, coeff_value, sample, zero pad
    logic            s_axis_tuser  = 1'b0; // cmd

    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata; // filtered
    logic             m_axis_tuser; // saturated

    polyphase_decimating_fir dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    // filter model state
    logic signed [SMP_BITS-1:0] tap_mem [DEPTH];
    logic signed [CF_BITS-1:0]  coef_mem [DEPTH];
    int                         phase_ctr;
    longint                     acc;
    logic [CFG_W-1:0]           decim_reg;

    fir_req_t pending_reqs [$];
    fir_out_t filt_expect [$];
    fir_req_t cur_req;
    bit       req_taken;
    int       send_gap;
    int       out_hold;
    bit       source_calm;
    bit       sink_calm;
    int       issued;
    int       n_fail;
    int       cycles;

    function automatic bit filter_step(input fir_req_t r, output fir_out_t res);
        int     m;
        int     br;
        int     base;
        longint dot;
        longint q;
        bit     clip;
        res.filtered  = '0;
        res.saturated = 1'b0;
        if (r.cmd == pdfir_pkg::CMD_COEF)
        begin
            coef_mem[r.idx] = r.coeff;
            return 1'b0;
        end
        m = (decim_reg < 1) ? 1 :
            (decim_reg > pdfir_pkg::MAX_DECIM_DEF) ? pdfir_pkg::MAX_DECIM_DEF :
            int'(decim_reg);
        br = phase_ctr % m;
        base = br * TAPS;
        for (int t = TAPS - 1; t > 0; t--)
            tap_mem[base + t] = tap_mem[base + t - 1];
        tap_mem[base] = r.smp;
        dot = 0;
        for (int t = 0; t < TAPS; t++)
            dot += longint'(coef_mem[base + t]) * longint'(tap_mem[base + t]);
        acc += dot;
        if (acc > longint'(pdfir_pkg::ACC_MAX))
            acc = longint'(pdfir_pkg::ACC_MAX);
        if (acc < longint'(pdfir_pkg::ACC_MIN))
            acc = longint'(pdfir_pkg::ACC_MIN);
        if (br + 1 < m)
        begin
            phase_ctr = br + 1;
            return 1'b0;
        end
        q = (acc + (64'sd1 <<< (pdfir_pkg::FRAC_BITS - 1))) >>> pdfir_pkg::FRAC_BITS;
        clip = 1'b0;
        if (q > 32767)
        begin
            q = 32767;
            clip = 1'b1;
        end
        if (q < -32768)
        begin
            q = -32768;
            clip = 1'b1;
        end
        res.filtered  = q[SMP_BITS-1:0];
        res.saturated = clip;
        acc = 0;
        phase_ctr = 0;
        return 1'b1;
    endfunction

    function automatic int idle_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // request driver
    always @(negedge clk)
    begin
        if (s_axis_tvalid && !req_taken)
        begin
        end
        else if (send_gap > 0)
        begin
            send_gap--;
            s_axis_tvalid <= 1'b0;
        end
        else if (pending_reqs.size() > 0)
        begin
            cur_req = pending_reqs.pop_front();
            s_axis_tdata  <= {{IN_PAD{1'b0}}, cur_req.smp, cur_req.coeff, cur_req.idx};
            s_axis_tuser  <= cur_req.cmd;
            s_axis_tvalid <= 1'b1;
            send_gap = idle_gap(source_calm);
        end
        else
        begin
            s_axis_tvalid <= 1'b0;
        end
        req_taken = 1'b0;
    end

    // output backpressure
    always @(negedge clk)
    begin
        if (out_hold == 0 && $urandom_range(0, 3) == 0)
            out_hold = idle_gap(sink_calm);
        if (out_hold > 0)
        begin
            out_hold--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // prediction and checking
    always @(posedge clk)
    begin
        fir_out_t r;
        fir_out_t want;
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("tb: failure");
            $finish;
        end
        else
        begin
            if (rst_n && s_axis_tvalid && s_axis_tready)
            begin
                req_taken = 1'b1;
                if (filter_step(cur_req, r))
                    filt_expect.push_back(r);
            end
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (filt_expect.size() == 0)
                begin
                    $error("unexpected output request: filtered %0d saturated %0d",
                           $signed(m_axis_tdata[SMP_BITS-1:0]), m_axis_tuser);
                    n_fail++;
                end
                else
                begin
                    want = filt_expect.pop_front();
                    if (m_axis_tdata[SMP_BITS-1:0] !== want.filtered)
                    begin
                        $error("filtered: expected %0d, actual %0d", want.filtered,
                               $signed(m_axis_tdata[SMP_BITS-1:0]));
                        n_fail++;
                    end
                    if (m_axis_tuser !== want.saturated)
                    begin
                        $error("saturated: expected %0d, actual %0d", want.saturated,
                               m_axis_tuser);
                        n_fail++;
                    end
                end
            end
        end
    end

    function automatic void push_coef(input int idx, input logic signed [CF_BITS-1:0] val);
        fir_req_t r;
        r.cmd   = pdfir_pkg::CMD_COEF;
        r.idx   = idx[IDX_BITS-1:0];
        r.coeff = val;
        r.smp   = SMP_BITS'($urandom);
        pending_reqs.push_back(r);
        issued++;
    endfunction

    function automatic void push_sample(input logic signed [SMP_BITS-1:0] s);
        fir_req_t r;
        r.cmd   = pdfir_pkg::CMD_SAMPLE;
        r.idx   = IDX_BITS'($urandom);
        r.coeff = CF_BITS'($urandom);
        r.smp   = s;
        pending_reqs.push_back(r);
        issued++;
    endfunction

    function automatic logic signed [CF_BITS-1:0] rand_coef(input int sh);
        logic signed [CF_BITS-1:0] c;
        c = CF_BITS'($urandom);
        return c >>> sh;
    endfunction

    function automatic logic signed [SMP_BITS-1:0] rand_sample(input int sh);
        logic signed [SMP_BITS-1:0] s;
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 16'sh7fff;
        if (r == 1)
            return 16'sh8000;
        s = SMP_BITS'($urandom);
        return s >>> sh;
    endfunction

    task automatic drain();
        while (pending_reqs.size() != 0 || s_axis_tvalid || filt_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_decimation(input logic [CFG_W-1:0] f);
        @(negedge clk);
        cfg_data  <= f;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        decim_reg = f;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int coef_sh;
        int smp_sh;
        int n;
        int pick;
        logic [CFG_W-1:0] f;
        for (int i = 0; i < DEPTH; i++)
            tap_mem[i] = '0;
        phase_ctr = 0;
        acc       = 0;
        decim_reg = pdfir_pkg::DECIM_RESET;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // fill the whole coefficient store first
        for (int i = 0; i < DEPTH; i++)
            push_coef(i, rand_coef($urandom_range(6, 12)));
        drain();

        // extreme coefficients and samples at the reset factor
        for (int i = 0; i < 4; i++)
            push_coef(i, 18'sh20000);
        push_coef(DEPTH - 1, 18'sh1ffff);
        push_sample(16'sh7fff);
        push_sample(16'sh8000);
        push_sample(16'sh0000);
        push_sample(16'shffff);
        drain();

        // one branch, driven into saturation both ways
        set_decimation(5'd1);
        repeat (3) push_sample(16'sh8000);
        repeat (3) push_sample(16'sh7fff);
        drain();

        // zero factor behaves as one
        set_decimation(5'd0);
        push_sample(16'sh0001);
        push_sample(16'shffff);
        drain();

        // oversized factor, then shrink in the middle of a cycle
        set_decimation(5'd31);
        for (int i = 0; i < 5; i++)
            push_sample(i[0] ? 16'sh8000 : 16'sh7fff);
        drain();
        set_decimation(5'd2);
        push_sample(16'sh4321);
        drain();

        while (issued < RAND_REQS)
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0: f = CFG_W'($urandom_range(17, 31));
                1: f = 5'd0;
                2: f = 5'd1;
                3: f = 5'd16;
                default: f = CFG_W'($urandom_range(2, 15));
            endcase
            set_decimation(f);
            source_calm = ($urandom_range(0, 3) == 0);
            sink_calm   = ($urandom_range(0, 3) == 0);
            coef_sh = $urandom_range(0, 12);
            smp_sh  = $urandom_range(0, 8);
            n = $urandom_range(0, 24);
            for (int i = 0; i < n; i++)
                push_coef($urandom_range(0, DEPTH - 1), rand_coef(coef_sh));
            n = $urandom_range(4, 120);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 99) < 15)
                    push_coef($urandom_range(0, DEPTH - 1), rand_coef(coef_sh));
                else
                    push_sample(rand_sample(smp_sh));
            end
            drain();
        end

        if (n_fail == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
